// ----- rtl/bem_pkg.sv -----
package bem_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_L,
    S_RD_R,
    S_WAIT,
    S_EMIT,
    S_CAPT
  } state_t;

  typedef enum logic [1:0] {
    ADDR_ELBOW,
    ADDR_RIGHT,
    ADDR_NEXT
  } addr_sel_t;

  typedef struct packed {
    logic      load;
    logic      start;
    logic      cap_l;
    logic      cap_r;
    logic      capture;
    logic      emit;
    addr_sel_t addr_sel;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic single;
    logic final_out;
    logic out_busy;
  } status_t;

endpackage

// ----- rtl/bem_ram.sv -----
module bem_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bem_ctrl.sv -----
module bem_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  bem_pkg::status_t  status,
  output bem_pkg::cmd_t     cmd
);

  bem_pkg::state_t state;
  bem_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bem_pkg::S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    cmd          = '0;
    cmd.addr_sel = bem_pkg::ADDR_NEXT;
    case (state)
      bem_pkg::S_LOAD: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
        if (s_tvalid && status.close) begin
          state_next = bem_pkg::S_RD_L;
        end
      end
      bem_pkg::S_RD_L: begin
        cmd.start    = 1'b1;
        cmd.addr_sel = bem_pkg::ADDR_ELBOW;
        state_next   = bem_pkg::S_RD_R;
      end
      bem_pkg::S_RD_R: begin
        cmd.cap_l    = 1'b1;
        cmd.addr_sel = bem_pkg::ADDR_RIGHT;
        state_next   = bem_pkg::S_WAIT;
      end
      bem_pkg::S_WAIT: begin
        cmd.cap_r  = 1'b1;
        state_next = bem_pkg::S_EMIT;
      end
      bem_pkg::S_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit   = 1'b1;
          state_next = status.final_out ? bem_pkg::S_LOAD : bem_pkg::S_CAPT;
        end
      end
      bem_pkg::S_CAPT: begin
        cmd.capture = 1'b1;
        state_next  = bem_pkg::S_EMIT;
      end
      default: begin
        state_next = bem_pkg::S_LOAD;
      end
    endcase
  end

  // A held output register must keep the merge parked in the emit state.
  a_park_on_stall: assert property (@(posedge clk) disable iff (rst)
    (state == bem_pkg::S_EMIT && status.out_busy) |=> state == bem_pkg::S_EMIT)
    else $error("merge left emit state while output stalled");

  // The final result of a row returns the block to loading.
  a_final_to_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && status.final_out) |=> state == bem_pkg::S_LOAD)
    else $error("final result did not return to load");

  // A closing item always starts the merge sequence.
  a_close_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && status.close) |=> state == bem_pkg::S_RD_L)
    else $error("closing item did not start merge");

endmodule

// ----- rtl/bem_datapath.sv -----
module bem_datapath #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_data,
  input  logic [bem_pkg::DATA_W-1:0] s_tdata,
  input  logic                       s_tlast,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [bem_pkg::DATA_W-1:0] m_tdata,
  output logic                       m_tlast,
  input  bem_pkg::cmd_t              cmd,
  output bem_pkg::status_t           status
);

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);

  logic                              ascending;
  logic [CW-1:0]                     fill_count;
  logic [AW-1:0]                     pos;
  logic [AW-1:0]                     elbow_index;
  logic signed [bem_pkg::DATA_W-1:0] elbow_value;
  logic [AW-1:0]                     last_idx;
  logic [AW-1:0]                     left;
  logic [AW-1:0]                     right;
  logic [AW-1:0]                     left_next;
  logic [AW-1:0]                     right_next;
  logic [AW-1:0]                     emit_cnt;
  logic signed [bem_pkg::DATA_W-1:0] lv;
  logic signed [bem_pkg::DATA_W-1:0] rv;
  logic                              took_left;
  logic                              take_left;
  logic                              new_elbow;
  logic signed [bem_pkg::DATA_W-1:0] v;
  logic [AW-1:0]                     raddr;
  logic [bem_pkg::DATA_W-1:0]        rdata;

  assign pos = fill_count[AW-1:0];
  assign v   = s_tdata;

  assign status.close     = s_tlast || (fill_count == CW'(MAX_LEN - 1));
  assign status.single    = (last_idx == '0);
  assign status.final_out = (emit_cnt == last_idx);
  assign status.out_busy  = m_tvalid && !m_tready;

  assign new_elbow = (pos == '0) ||
                     (ascending ? (v < elbow_value) : (elbow_value < v));

  // Tie goes to the left side.
  assign take_left  = status.single || (ascending ? !(rv < lv) : !(lv < rv));
  assign left_next  = (left == '0) ? last_idx : left - AW'(1);
  assign right_next = (right == last_idx) ? '0 : right + AW'(1);

  always_comb begin
    case (cmd.addr_sel)
      bem_pkg::ADDR_ELBOW: raddr = elbow_index;
      bem_pkg::ADDR_RIGHT: raddr = right;
      default:             raddr = take_left ? left_next : right_next;
    endcase
  end

  bem_ram #(
    .WIDTH (bem_pkg::DATA_W),
    .DEPTH (MAX_LEN)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (pos),
    .wdata (s_tdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ascending   <= 1'b1;
      fill_count  <= '0;
      elbow_index <= '0;
      elbow_value <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        ascending <= cfg_data;
      end
      if (cmd.load) begin
        if (new_elbow) begin
          elbow_index <= pos;
          elbow_value <= v;
        end
        fill_count <= status.close ? '0 : fill_count + CW'(1);
      end
      if (cmd.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && status.close) begin
      last_idx <= pos;
    end
    if (cmd.start) begin
      left     <= elbow_index;
      right    <= (elbow_index == last_idx) ? '0 : elbow_index + AW'(1);
      emit_cnt <= '0;
    end
    if (cmd.cap_l) begin
      lv <= rdata;
    end
    if (cmd.cap_r) begin
      rv <= rdata;
    end
    if (cmd.capture) begin
      if (took_left) begin
        lv <= rdata;
      end else begin
        rv <= rdata;
      end
    end
    if (cmd.emit) begin
      m_tdata   <= take_left ? lv : rv;
      m_tlast   <= status.final_out;
      took_left <= take_left;
      if (!status.single) begin
        if (take_left) begin
          left <= left_next;
        end else begin
          right <= right_next;
        end
      end
      if (!status.final_out) begin
        emit_cnt <= emit_cnt + AW'(1);
      end
    end
  end

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill_count < CW'(MAX_LEN))
    else $error("fill count out of range");

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (left <= last_idx && right <= last_idx && emit_cnt <= last_idx))
    else $error("merge pointer beyond row");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> m_tvalid)
    else $error("emitted result not presented");

endmodule

// ----- rtl/bitonic_elbow_merge_sort.sv -----
// Load: one item per cycle, s_tready high whenever the block is loading.
// Merge: after the closing item, S_RD_L, S_RD_R and S_WAIT read the elbow and its
//   right neighbour; then S_EMIT (held while the output stalls) and S_CAPT alternate,
//   set by the single registered read port of the row buffer (address, then data).
// Reset (rst, synchronous, active high) clears the controller, fill count, elbow
//   and output valid and sets ascending; the row buffer is not cleared.
module bitonic_elbow_merge_sort #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk,
  input  logic        rst,
  // Configuration: ascending register, written when cfg_we is high.
  input  logic        cfg_we,
  input  logic        cfg_data,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic        s_tlast,   // last_in
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] sorted_value
  output logic        m_tlast    // last_out
);

  // Command and status between the sequencer and the datapath.
  bem_pkg::cmd_t    cmd;
  bem_pkg::status_t status;

  // Sequencer: load the row, then walk the merge one result at a time.
  bem_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: row buffer, elbow tracking, ring pointers, compare and output register.
  bem_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .status   (status)
  );

endmodule
